// ===== src/msws_pkg.sv =====
package msws_pkg;

  localparam int NUM_WHEELS  = 4;
  localparam int SPEED_W     = 16;
  localparam int LIMIT_W     = 15;
  localparam int WM_W        = 15;
  localparam int OFFSET_W    = 32;
  localparam int K_W         = 31;
  localparam int R_W         = 34;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_TURN_BASE_COEF     = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TURN_X_OFFSET_COEF = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TURN_Y_OFFSET_COEF = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_TO_RPM_COEF  = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_RPM_LIMIT    = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_SPEED_LIMIT  = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SECOND_SPEED_LIMIT = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_TURN_RATE_LIMIT    = 4'd7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'h7fff;
  localparam logic [WM_W-1:0]    SAT_MAG     = 15'h7fff;

  // Wheel order: front right, front left, back left, back right (bit i is wheel i).
  localparam logic [NUM_WHEELS-1:0] FIRST_NEG  = 4'b0011;
  localparam logic [NUM_WHEELS-1:0] SECOND_NEG = 4'b1001;
  localparam logic [NUM_WHEELS-1:0] X_NEG      = 4'b0011;
  localparam logic [NUM_WHEELS-1:0] Y_NEG      = 4'b0110;

  typedef struct packed {
    logic signed [SPEED_W-1:0] first_speed;
    logic signed [SPEED_W-1:0] second_speed;
    logic signed [SPEED_W-1:0] turn_rate;
    logic                      mode;
  } cmd_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] wheel_front_right;
    logic signed [SPEED_W-1:0] wheel_front_left;
    logic signed [SPEED_W-1:0] wheel_back_left;
    logic signed [SPEED_W-1:0] wheel_back_right;
  } result_t;

endpackage

// ===== src/msws_stream_if.sv =====
interface msws_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/msws_lane.sv =====
module msws_lane #(
  parameter int COEF_FRAC_BITS = 20,
  parameter int LANE = 0
) (
  input  logic                               clk,
  input  logic [3:0]                         adv,
  input  logic signed [msws_pkg::SPEED_W-1:0] first_speed,
  input  logic signed [msws_pkg::SPEED_W-1:0] second_speed,
  input  logic signed [msws_pkg::SPEED_W-1:0] turn_rate,
  input  logic signed [msws_pkg::R_W-1:0]     ratio,
  input  logic [msws_pkg::K_W-1:0]            rpm_coef,
  output logic [msws_pkg::WM_W-1:0]           mag,
  output logic                                neg
);
  import msws_pkg::*;

  localparam int LIN_W  = SPEED_W + 1;
  localparam int PROD_W = SPEED_W + R_W;
  localparam int LS_W   = LIN_W + COEF_FRAC_BITS;
  localparam int S_W    = ((LS_W > PROD_W) ? LS_W : PROD_W) + 1;
  localparam int MAG_W  = S_W - 1;
  localparam int LO_W   = MAG_W / 2;
  localparam int HI_W   = MAG_W - LO_W;
  localparam int P_W    = MAG_W + K_W;
  localparam int SH     = 2 * COEF_FRAC_BITS;

  logic signed [LIN_W-1:0]  fs_ext, ss_ext, lin_c;
  logic signed [PROD_W-1:0] prod_c;
  logic signed [LIN_W-1:0]  lin2;
  logic signed [PROD_W-1:0] prod2;
  logic signed [S_W-1:0]    s_c, s_abs;
  logic [MAG_W-1:0]         mag3;
  logic                     neg3;
  logic [LO_W+K_W-1:0]      pl4;
  logic [HI_W+K_W-1:0]      ph4;
  logic                     neg4;
  logic [P_W-1:0]           p_c;
  logic                     sat_c;

  assign fs_ext = {first_speed[SPEED_W-1], first_speed};
  assign ss_ext = {second_speed[SPEED_W-1], second_speed};
  assign lin_c  = (FIRST_NEG[LANE] ? -fs_ext : fs_ext) + (SECOND_NEG[LANE] ? -ss_ext : ss_ext);
  assign prod_c = turn_rate * ratio;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      lin2  <= lin_c;
      prod2 <= prod_c;
    end
  end

  assign s_c   = (S_W'(lin2) <<< COEF_FRAC_BITS) - S_W'(prod2);
  assign s_abs = s_c[S_W-1] ? -s_c : s_c;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      neg3 <= s_c[S_W-1];
      mag3 <= s_abs[MAG_W-1:0];
    end
  end

  // The magnitude times the rpm factor is split in two partial products.
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      pl4  <= mag3[LO_W-1:0] * rpm_coef;
      ph4  <= mag3[MAG_W-1:LO_W] * rpm_coef;
      neg4 <= neg3;
    end
  end

  assign p_c   = P_W'(pl4) + (P_W'(ph4) << LO_W);
  assign sat_c = |p_c[P_W-1:SH+WM_W];

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      mag <= sat_c ? SAT_MAG : p_c[SH+WM_W-1:SH];
      neg <= neg4;
    end
  end

endmodule

// ===== src/msws_div_stage.sv =====
module msws_div_stage #(
  parameter int STEPS = 4
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [msws_pkg::WM_W-1:0] divisor,
  input  logic [msws_pkg::WM_W-1:0] rem_in,
  input  logic [msws_pkg::WM_W-1:0] quo_in,
  output logic [msws_pkg::WM_W-1:0] rem,
  output logic [msws_pkg::WM_W-1:0] quo
);
  import msws_pkg::*;

  logic [WM_W-1:0] rem_c, quo_c;
  logic [WM_W:0]   trial;
  logic            take;

  // Restoring division: quo holds the numerator bits still to come in its top
  // and collects quotient bits at the bottom.
  always_comb begin
    rem_c = rem_in;
    quo_c = quo_in;
    trial = '0;
    take  = 1'b0;
    for (int j = 0; j < STEPS; j++) begin
      trial = {rem_c, quo_c[WM_W-1]};
      take  = (trial >= {1'b0, divisor});
      if (take) begin
        rem_c = WM_W'(trial - {1'b0, divisor});
      end else begin
        rem_c = trial[WM_W-1:0];
      end
      quo_c = {quo_c[WM_W-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem <= rem_c;
      quo <= quo_c;
    end
  end

endmodule

// ===== src/mecanum_wheel_speed_solver.sv =====
// Mecanum wheel speed solver: chassis velocity command in, four wheel rpm out.
//
// cmd carries one command per transaction (first/second linear speed, turn
// rate, mode); wheels carries the four wheel speeds of that command. Both are
// valid/ready channels; a transaction completes when valid and ready are high.
// The configuration port writes register cfg_index with cfg_data when cfg_we
// is high; indexes 8 and above are ignored. Write it only while no command is
// in flight.
//
// wheels.valid rises when the command reaches the last stage. One command
// can enter every cycle while the output is not stalled; the two registered
// multiplier stages per wheel, the max search and a four-stage divider (four,
// four, four and three quotient bits) set the depth. Each stage has its own
// valid bit and holds while it is full and the stage after it cannot take
// its item, so a stalled receiver backs the pipeline up without losing data
// and empty stages still fill. Reset clears all valid bits and loads the
// registers with zero coefficients and limits of 32767.
module mecanum_wheel_speed_solver #(
  parameter int COEF_FRAC_BITS = 20
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [msws_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [msws_pkg::CFG_DATA_W-1:0]    cfg_data,
  msws_stream_if.sink                        cmd,
  msws_stream_if.source                      wheels
);
  import msws_pkg::*;

  localparam int DIV_STAGES = 4;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_FIRST  = 8;
  localparam int NSTAGE     = DIV_FIRST + DIV_STAGES;

  // Configuration registers.
  logic [K_W-1:0]             turn_base_coef;
  logic signed [OFFSET_W-1:0] turn_x_offset_coef;
  logic signed [OFFSET_W-1:0] turn_y_offset_coef;
  logic [K_W-1:0]             speed_to_rpm_coef;
  logic [LIMIT_W-1:0]         rpm_limit;
  logic [LIMIT_W-1:0]         first_speed_limit;
  logic [LIMIT_W-1:0]         second_speed_limit;
  logic [LIMIT_W-1:0]         turn_rate_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_base_coef     <= '0;
      turn_x_offset_coef <= '0;
      turn_y_offset_coef <= '0;
      speed_to_rpm_coef  <= '0;
      rpm_limit          <= LIMIT_RESET;
      first_speed_limit  <= LIMIT_RESET;
      second_speed_limit <= LIMIT_RESET;
      turn_rate_limit    <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TURN_BASE_COEF:     turn_base_coef     <= cfg_data[K_W-1:0];
        REG_TURN_X_OFFSET_COEF: turn_x_offset_coef <= cfg_data[OFFSET_W-1:0];
        REG_TURN_Y_OFFSET_COEF: turn_y_offset_coef <= cfg_data[OFFSET_W-1:0];
        REG_SPEED_TO_RPM_COEF:  speed_to_rpm_coef  <= cfg_data[K_W-1:0];
        REG_WHEEL_RPM_LIMIT:    rpm_limit          <= cfg_data[LIMIT_W-1:0];
        REG_FIRST_SPEED_LIMIT:  first_speed_limit  <= cfg_data[LIMIT_W-1:0];
        REG_SECOND_SPEED_LIMIT: second_speed_limit <= cfg_data[LIMIT_W-1:0];
        REG_TURN_RATE_LIMIT:    turn_rate_limit    <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: a stage loads when it is empty or its contents move on.
  logic [NSTAGE:1]   v;
  logic [NSTAGE:1]   v_in;
  logic [NSTAGE+1:1] en;

  always_comb begin
    en[NSTAGE+1] = wheels.ready;
    for (int s = NSTAGE; s >= 1; s--) begin
      en[s] = !v[s] || en[s+1];
    end
  end

  assign v_in = {v[NSTAGE-1:1], cmd.valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int s = 1; s <= NSTAGE; s++) begin
        if (en[s]) begin
          v[s] <= v_in[s];
        end
      end
    end
  end

  assign cmd.ready    = en[1];
  assign wheels.valid = v[NSTAGE];

  // Stage 1: clamp the command (the turn rate only when mode is low) and form the per-wheel rotation ratios.
  function automatic logic signed [SPEED_W-1:0] clamp_sym(
    input logic signed [SPEED_W-1:0] val,
    input logic [LIMIT_W-1:0]        lim
  );
    logic signed [SPEED_W:0] lim_s;
    logic signed [SPEED_W:0] val_s;
    lim_s = {2'b00, lim};
    val_s = {val[SPEED_W-1], val};
    if (val_s > lim_s) begin
      return SPEED_W'(lim_s);
    end else if (val_s < -lim_s) begin
      return SPEED_W'(-lim_s);
    end
    return val;
  endfunction

  logic signed [R_W-1:0]     base_ext, x_ext, y_ext;
  logic signed [R_W-1:0]     r_c [NUM_WHEELS];
  logic signed [SPEED_W-1:0] fs1, ss1, tr1;
  logic signed [R_W-1:0]     r1 [NUM_WHEELS];

  assign base_ext = {{(R_W-K_W){1'b0}}, turn_base_coef};
  assign x_ext    = {{(R_W-OFFSET_W){turn_x_offset_coef[OFFSET_W-1]}}, turn_x_offset_coef};
  assign y_ext    = {{(R_W-OFFSET_W){turn_y_offset_coef[OFFSET_W-1]}}, turn_y_offset_coef};

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      r_c[i] = base_ext + (X_NEG[i] ? -x_ext : x_ext) + (Y_NEG[i] ? -y_ext : y_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      fs1 <= clamp_sym(cmd.data.first_speed, first_speed_limit);
      ss1 <= clamp_sym(cmd.data.second_speed, second_speed_limit);
      tr1 <= cmd.data.mode ? cmd.data.turn_rate
                           : clamp_sym(cmd.data.turn_rate, turn_rate_limit);
      for (int i = 0; i < NUM_WHEELS; i++) begin
        r1[i] <= r_c[i];
      end
    end
  end

  // Stages 2 to 5: one lane per wheel.
  logic [WM_W-1:0]       q5 [NUM_WHEELS];
  logic [NUM_WHEELS-1:0] neg5;

  for (genvar i = 0; i < NUM_WHEELS; i++) begin : g_lane
    msws_lane #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS),
      .LANE(i)
    ) u_lane (
      .clk(clk),
      .adv(en[5:2]),
      .first_speed(fs1),
      .second_speed(ss1),
      .turn_rate(tr1),
      .ratio(r1[i]),
      .rpm_coef(speed_to_rpm_coef),
      .mag(q5[i]),
      .neg(neg5[i])
    );
  end

  // Stage 6: scaling numerators and the first level of the max search.
  logic [2*WM_W-1:0]     n6 [NUM_WHEELS];
  logic [WM_W-1:0]       a6 [NUM_WHEELS];
  logic [NUM_WHEELS-1:0] neg6;
  logic [WM_W-1:0]       m01_6, m23_6;
  logic [LIMIT_W-1:0]    lim6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        n6[i] <= q5[i] * rpm_limit;
        a6[i] <= q5[i];
      end
      neg6  <= neg5;
      m01_6 <= (q5[0] > q5[1]) ? q5[0] : q5[1];
      m23_6 <= (q5[2] > q5[3]) ? q5[2] : q5[3];
      lim6  <= rpm_limit;
    end
  end

  // Stage 7: largest magnitude and the scaling decision.
  logic [2*WM_W-1:0]     n7 [NUM_WHEELS];
  logic [WM_W-1:0]       a7 [NUM_WHEELS];
  logic [NUM_WHEELS-1:0] neg7;
  logic [WM_W-1:0]       mx_c, mx7;
  logic                  scale7;

  assign mx_c = (m01_6 > m23_6) ? m01_6 : m23_6;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        n7[i] <= n6[i];
        a7[i] <= a6[i];
      end
      neg7   <= neg6;
      mx7    <= mx_c;
      scale7 <= (mx_c > lim6);
    end
  end

  // Stages 8 to 11: divide each numerator by the largest magnitude. The
  // quotient never exceeds the limit, so the top half of the numerator is
  // already below the divisor.
  logic [WM_W-1:0]       rem_d [DIV_STAGES][NUM_WHEELS];
  logic [WM_W-1:0]       quo_d [DIV_STAGES][NUM_WHEELS];
  logic [WM_W-1:0]       a_d   [DIV_STAGES][NUM_WHEELS];
  logic [NUM_WHEELS-1:0] neg_d [DIV_STAGES];
  logic [WM_W-1:0]       mx_d  [DIV_STAGES];
  logic [DIV_STAGES-1:0] scale_d;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    localparam int STEPS = (k == DIV_STAGES - 1) ? WM_W - DIV_STEPS * (DIV_STAGES - 1)
                                                 : DIV_STEPS;
    logic [WM_W-1:0] divisor;

    if (k == 0) begin : g_first
      assign divisor = mx7;
    end else begin : g_next
      assign divisor = mx_d[k-1];
    end

    for (genvar i = 0; i < NUM_WHEELS; i++) begin : g_wheel
      logic [WM_W-1:0] rem_in, quo_in;

      if (k == 0) begin : g_first
        assign rem_in = n7[i][2*WM_W-1:WM_W];
        assign quo_in = n7[i][WM_W-1:0];
      end else begin : g_next
        assign rem_in = rem_d[k-1][i];
        assign quo_in = quo_d[k-1][i];
      end

      msws_div_stage #(
        .STEPS(STEPS)
      ) u_div (
        .clk(clk),
        .en(en[DIV_FIRST+k]),
        .divisor(divisor),
        .rem_in(rem_in),
        .quo_in(quo_in),
        .rem(rem_d[k][i]),
        .quo(quo_d[k][i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en[DIV_FIRST]) begin
      a_d[0]     <= a7;
      neg_d[0]   <= neg7;
      mx_d[0]    <= mx7;
      scale_d[0] <= scale7;
    end
    for (int k = 1; k < DIV_STAGES; k++) begin
      if (en[DIV_FIRST+k]) begin
        a_d[k]     <= a_d[k-1];
        neg_d[k]   <= neg_d[k-1];
        mx_d[k]    <= mx_d[k-1];
        scale_d[k] <= scale_d[k-1];
      end
    end
  end

  // Stage 12: pick scaled or plain magnitude and restore the sign.
  logic [SPEED_W-1:0] mag16_c [NUM_WHEELS];
  logic [SPEED_W-1:0] w_c     [NUM_WHEELS];
  logic [SPEED_W-1:0] out_w   [NUM_WHEELS];

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      mag16_c[i] = {1'b0, (scale_d[DIV_STAGES-1] ? quo_d[DIV_STAGES-1][i]
                                                 : a_d[DIV_STAGES-1][i])};
      w_c[i] = neg_d[DIV_STAGES-1][i] ? SPEED_W'(0 - mag16_c[i]) : mag16_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NSTAGE]) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        out_w[i] <= w_c[i];
      end
    end
  end

  assign wheels.data.wheel_front_right = out_w[0];
  assign wheels.data.wheel_front_left  = out_w[1];
  assign wheels.data.wheel_back_left   = out_w[2];
  assign wheels.data.wheel_back_right  = out_w[3];

  // A full stage that cannot move on keeps its item.
  assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ((v & $past(v & ~en[NSTAGE:1])) == $past(v & ~en[NSTAGE:1])))
    else $error("pipeline stage dropped a held item");

  assert property (@(posedge clk) disable iff (rst)
    v[7] |-> (mx7 >= a7[0]) && (mx7 >= a7[1]) && (mx7 >= a7[2]) && (mx7 >= a7[3]))
    else $error("max search below a wheel magnitude");

  assert property (@(posedge clk) disable iff (rst)
    (v[NSTAGE-1] && scale_d[DIV_STAGES-1]) |->
      (quo_d[DIV_STAGES-1][0] <= a_d[DIV_STAGES-1][0]) &&
      (quo_d[DIV_STAGES-1][1] <= a_d[DIV_STAGES-1][1]) &&
      (quo_d[DIV_STAGES-1][2] <= a_d[DIV_STAGES-1][2]) &&
      (quo_d[DIV_STAGES-1][3] <= a_d[DIV_STAGES-1][3]))
    else $error("scaled wheel speed grew");

  assert property (@(posedge clk) disable iff (rst)
    wheels.valid |-> (out_w[0] != 16'h8000) && (out_w[1] != 16'h8000) &&
                     (out_w[2] != 16'h8000) && (out_w[3] != 16'h8000))
    else $error("wheel speed outside the saturation range");

endmodule
